// ----- src/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the interleave stream scheduler.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int MAX_STREAMS = 4;
	localparam int IDX_W       = 2;
	localparam int TIME_W      = 64;
	localparam int WORD_W      = 32;
	localparam int CFG_IDX_W   = 4;

	localparam logic [WORD_W-1:0] RATE_RESET = 32'd90000;

	// Register groups, selected by cfg_index[3:2]
	localparam logic [1:0] CFG_GRP_START = 2'b00;
	localparam logic [1:0] CFG_GRP_RATE  = 2'b01;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  sidx_t;

	// Selection result handed from the merge unit to the top level
	typedef struct packed {
		logic  done;
		logic  have;
		sidx_t best;
	} sel_t;

endpackage

// ----- src/iss_lane.sv -----
// ----------------------------------------------------------------------------
// iss_lane
// Per-stream key lane: registers raw next time and biased preference key.
// ----------------------------------------------------------------------------
module iss_lane (
	input  logic          clk,
	input  iss_pkg::time_t next_time,
	input  iss_pkg::word_t rate,
	input  logic          is_last,
	output iss_pkg::time_t key_s1,
	output iss_pkg::time_t raw_s1
);

	iss_pkg::time_t bias;

	// last chosen stream gets no bias
	assign bias = is_last ? '0 : iss_pkg::TIME_W'(rate >> 2);

	always_ff @(posedge clk) begin
		raw_s1 <= next_time;
		key_s1 <= next_time + bias;
	end

endmodule

// ----- src/iss_merge.sv -----
// ----------------------------------------------------------------------------
// iss_merge
// Merge stage: walks the lanes one per cycle and keeps the current candidate.
// ----------------------------------------------------------------------------
module iss_merge #(
	parameter int NUM_STREAMS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [iss_pkg::MAX_STREAMS-1:0]    mask,
	input  iss_pkg::time_t                     key_s1 [iss_pkg::MAX_STREAMS],
	input  iss_pkg::time_t                     raw_s1 [iss_pkg::MAX_STREAMS],
	output iss_pkg::sel_t                      sel
);

	localparam iss_pkg::sidx_t LAST_IDX = iss_pkg::IDX_W'(NUM_STREAMS - 1);

	logic           busy_q;
	logic           done_q;
	logic           have_q;
	iss_pkg::sidx_t idx_q;
	iss_pkg::sidx_t best_q;
	iss_pkg::time_t best_key_q;
	logic           take;

	// replace the candidate only when this lane's raw time is strictly below the candidate's biased key
	assign take = mask[idx_q] && (!have_q || (raw_s1[idx_q] < best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			have_q <= 1'b0;
			idx_q  <= '0;
			best_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			have_q <= 1'b0;
			idx_q  <= '0;
			best_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				have_q <= 1'b1;
				best_q <= idx_q;
			end
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && take) begin
			best_key_q <= key_s1[idx_q];
		end
	end

	assign sel = '{done: done_q, have: have_q, best: best_q};

endmodule

// ----- src/interleave_stream_scheduler.sv -----
// ----------------------------------------------------------------------------
// interleave_stream_scheduler
// Picks the next frame among up to four media streams and places it in the
// shared data area, tracking contiguous runs per stream.
// ----------------------------------------------------------------------------
// The request is captured, the merge stage steps through one stream lane per
//   cycle, and the result is then registered in the output register; no new
//   item is accepted until the previous result has been committed there.
// A finished result waits in the output register; a new item is taken meanwhile.
// Reset (arst_n low, asynchronous): times, offset, run count and history clear,
//   rates return to 90000. Config writes are always ready.
// ----------------------------------------------------------------------------
module interleave_stream_scheduler #(
	parameter int NUM_STREAMS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [iss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [iss_pkg::TIME_W-1:0]        cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [3:0]                        head_mask,
	input  logic [31:0]                       dur_0,
	input  logic [31:0]                       dur_1,
	input  logic [31:0]                       dur_2,
	input  logic [31:0]                       dur_3,
	input  logic [31:0]                       len_0,
	input  logic [31:0]                       len_1,
	input  logic [31:0]                       len_2,
	input  logic [31:0]                       len_3,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [1:0]                        chosen,
	output logic [31:0]                       data_offset,
	output logic                              new_run,
	output logic [31:0]                       run_total,
	output logic [31:0]                       end_offset
);

	localparam int MS = iss_pkg::MAX_STREAMS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} state_t;

	state_t state_q;

	// scheduler state
	iss_pkg::time_t next_time_q [MS];
	iss_pkg::word_t rate_q      [MS];
	iss_pkg::word_t stream_end_q[MS];
	logic [MS-1:0]  started_q;
	iss_pkg::sidx_t last_q;
	logic           last_valid_q;
	iss_pkg::word_t wr_off_q;
	iss_pkg::word_t run_q;

	// captured request
	logic [MS-1:0]  mask_q;
	iss_pkg::word_t dur_q[MS];
	iss_pkg::word_t len_q[MS];

	// output register
	logic           out_valid_q;
	logic           found_q;
	iss_pkg::sidx_t chosen_q;
	iss_pkg::word_t data_off_q;
	logic           new_run_q;
	iss_pkg::word_t run_total_q;
	iss_pkg::word_t end_off_q;

	// lane and merge wiring
	iss_pkg::time_t key_s1[MS];
	iss_pkg::time_t raw_s1[MS];
	iss_pkg::sel_t  sel;

	logic           in_xfer;
	logic           out_free;
	logic           commit;
	logic           nr;
	iss_pkg::word_t off_next;
	iss_pkg::word_t run_next;
	logic [MS-1:0]  lane_mask;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign commit    = out_free && ((state_q == ST_SCAN && sel.done) || (state_q == ST_WAIT));

	// mask bits beyond the built lanes are dropped
	always_comb begin
		lane_mask = '0;
		for (int s = 0; s < NUM_STREAMS; s++) begin
			lane_mask[s] = 1'b1;
		end
	end

	// one lane per stream forms the raw time and the biased key
	for (genvar s = 0; s < MS; s++) begin : g_lane
		if (s < NUM_STREAMS) begin : g_on
			iss_lane u_lane (
				.clk      (clk),
				.next_time(next_time_q[s]),
				.rate     (rate_q[s]),
				.is_last  (last_valid_q && (last_q == iss_pkg::IDX_W'(s))),
				.key_s1   (key_s1[s]),
				.raw_s1   (raw_s1[s])
			);
		end else begin : g_off
			assign key_s1[s] = '0;
			assign raw_s1[s] = '0;
		end
	end

	iss_merge #(
		.NUM_STREAMS(NUM_STREAMS)
	) u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_xfer),
		.mask  (mask_q),
		.key_s1(key_s1),
		.raw_s1(raw_s1),
		.sel   (sel)
	);

	// placement of the chosen frame
	assign nr       = !started_q[sel.best] || (stream_end_q[sel.best] != wr_off_q);
	assign off_next = wr_off_q + len_q[sel.best];
	assign run_next = run_q + iss_pkg::WORD_W'(nr);

	// hold the request while the merge stage walks the lanes
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mask_q   <= head_mask & lane_mask;
			dur_q[0] <= dur_0;
			dur_q[1] <= dur_1;
			dur_q[2] <= dur_2;
			dur_q[3] <= dur_3;
			len_q[0] <= len_0;
			len_q[1] <= len_1;
			len_q[2] <= len_2;
			len_q[3] <= len_3;
		end
		// the end of each stream's last frame is only read once the stream started
		if (commit && sel.have) begin
			stream_end_q[sel.best] <= off_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int s = 0; s < MS; s++) begin
				next_time_q[s] <= '0;
				rate_q[s]      <= iss_pkg::RATE_RESET;
			end
			started_q    <= '0;
			last_q       <= '0;
			last_valid_q <= 1'b0;
			wr_off_q     <= '0;
			run_q        <= '0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			chosen_q     <= '0;
			data_off_q   <= '0;
			new_run_q    <= 1'b0;
			run_total_q  <= '0;
			end_off_q    <= '0;
		end else begin
			// configuration: start time writes also load the stream's time
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index[3:2])
					iss_pkg::CFG_GRP_START: begin
						next_time_q[cfg_index[1:0]] <= cfg_data;
					end
					iss_pkg::CFG_GRP_RATE: begin
						rate_q[cfg_index[1:0]] <= cfg_data[iss_pkg::WORD_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// drop the result once the far side takes it
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sel.done) begin
						state_q <= out_free ? ST_IDLE : ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q <= 1'b1;
				if (sel.have) begin
					found_q      <= 1'b1;
					chosen_q     <= sel.best;
					data_off_q   <= wr_off_q;
					new_run_q    <= nr;
					run_total_q  <= run_next;
					end_off_q    <= off_next;
					// advance the stream and the data area
					started_q[sel.best]   <= 1'b1;
					wr_off_q              <= off_next;
					run_q                 <= run_next;
					next_time_q[sel.best] <= next_time_q[sel.best]
						+ iss_pkg::TIME_W'(dur_q[sel.best]);
					last_q                <= sel.best;
					last_valid_q          <= 1'b1;
				end else begin
					found_q     <= 1'b0;
					chosen_q    <= '0;
					data_off_q  <= wr_off_q;
					new_run_q   <= 1'b0;
					run_total_q <= run_q;
					end_off_q   <= wr_off_q;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign chosen      = chosen_q;
	assign data_offset = data_off_q;
	assign new_run     = new_run_q;
	assign run_total   = run_total_q;
	assign end_offset  = end_off_q;

endmodule

// ----- src/iss_checker.sv -----
// ----------------------------------------------------------------------------
// iss_checker
// Port-level checks for the interleave stream scheduler, bound to the top.
// ----------------------------------------------------------------------------
module iss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [1:0]  chosen,
	input logic [31:0] data_offset,
	input logic        new_run,
	input logic [31:0] end_offset
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// one item at a time: a transfer closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	// a result only appears after an item was in flight
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a pending item");

	// an empty result places nothing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (chosen == 2'd0) && !new_run && (data_offset == end_offset))
		else $error("empty result carries a placement");

endmodule

bind interleave_stream_scheduler iss_checker u_iss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.found      (found),
	.chosen     (chosen),
	.data_offset(data_offset),
	.new_run    (new_run),
	.end_offset (end_offset)
);
